// ===== hw/rtl/drd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the detection row decoder.
// No dependencies; every other file imports this package.
package drd_pkg;

    localparam int SAMPLE_W    = 20;
    localparam int PROB_W      = 17;
    localparam int COORD_W     = 17;
    localparam int SIZE_W      = 16;
    localparam int INDEX_W     = 7;
    localparam int COUNT_W     = 8;
    localparam int POS_W       = 8;
    localparam int FRAC_BITS   = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [PROB_W-1:0]  PROB_ONE        = 17'h10000;
    localparam logic [PROB_W-1:0]  THRESHOLD_RESET = 17'd16384;
    localparam logic [COUNT_W-1:0] CLASS_RESET     = 8'd80;

    localparam logic [POS_W-1:0] POS_CENTER_X = 8'd0;
    localparam logic [POS_W-1:0] POS_CENTER_Y = 8'd1;
    localparam logic [POS_W-1:0] POS_SIZE_W   = 8'd2;
    localparam logic [POS_W-1:0] POS_SIZE_H   = 8'd3;
    localparam logic [POS_W-1:0] POS_CONF     = 8'd4;
    localparam logic [POS_W-1:0] POS_FIRST    = 8'd5;

    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_CLASS_COUNT = 1'b1;

    typedef struct packed {
        logic [PROB_W-1:0]  threshold;
        logic [COUNT_W-1:0] class_count;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [INDEX_W-1:0]        index;
        logic [PROB_W-1:0]         best;
        logic [PROB_W-1:0]         conf;
    } t_box;

endpackage

// ===== hw/rtl/drd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the detection row decoder: input samples and results.
// Depends on drd_pkg for the field widths.
interface drd_in_if import drd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface drd_out_if import drd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
    logic [INDEX_W-1:0]        class_index;
    logic [PROB_W-1:0]         detection_score;

    modport source (output valid, output box_left, output box_top, output box_width,
                    output box_height, output class_index, output detection_score,
                    input ready);
    modport sink (input valid, input box_left, input box_top, input box_width,
                  input box_height, input class_index, input detection_score,
                  output ready);
endinterface

// ===== hw/rtl/drd_row_track.sv =====
`timescale 1ns / 1ps
// Row position tracking, box capture and running class maximum.
// Depends on drd_pkg; produces the box of a finished row when it passes the threshold.
module drd_row_track import drd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  t_cfg                i_cfg,
    output logic                o_emit,
    output t_box                o_box
);

    localparam int LAST_W = POS_W + 2;
    localparam logic [COUNT_W:0] MAX_COUNT = (COUNT_W + 1)'(MAX_CLASSES);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]  r_cx, r_cy, r_w, r_h;
    logic [PROB_W-1:0]  r_conf, r_best, n_best;
    logic [INDEX_W-1:0] r_index, n_index;

    logic [PROB_W-1:0]  w_prob;
    logic [COUNT_W:0]   w_count;
    logic [LAST_W-1:0]  w_last;
    logic               w_is_class;
    logic               w_take;
    logic               w_row_end;
    logic [POS_W-1:0]   w_class_pos;

    always_comb begin
        if (i_sample_value > SAMPLE_W'(PROB_ONE)) begin
            w_prob = PROB_ONE;
        end else begin
            w_prob = i_sample_value[PROB_W-1:0];
        end
        w_count = {1'b0, i_cfg.class_count};
        if (w_count == '0) begin
            w_count = (COUNT_W + 1)'(1);
        end else if (w_count > MAX_COUNT) begin
            w_count = MAX_COUNT;
        end
        w_last      = LAST_W'(POS_CONF) + LAST_W'(w_count);
        w_is_class  = (r_pos >= POS_FIRST);
        w_take      = (r_pos == POS_FIRST) || (w_prob > r_best);
        w_row_end   = w_is_class && (LAST_W'(r_pos) >= w_last);
        w_class_pos = r_pos - POS_FIRST;
        n_best      = w_take ? w_prob : r_best;
        n_index     = w_take ? w_class_pos[INDEX_W-1:0] : r_index;
        n_pos       = w_row_end ? '0 : r_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_conf  <= '0;
            r_best  <= '0;
            r_index <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            unique case (r_pos)
                POS_CENTER_X: r_cx <= i_sample_value[SAMPLE_W-1:FRAC_BITS];
                POS_CENTER_Y: r_cy <= i_sample_value[SAMPLE_W-1:FRAC_BITS];
                POS_SIZE_W:   r_w <= i_sample_value[SAMPLE_W-1:FRAC_BITS];
                POS_SIZE_H:   r_h <= i_sample_value[SAMPLE_W-1:FRAC_BITS];
                POS_CONF:     r_conf <= w_prob;
                default: begin
                    r_best  <= n_best;
                    r_index <= n_index;
                end
            endcase
        end
    end

    assign o_emit       = i_accept && w_row_end && (r_conf > i_cfg.threshold);
    assign o_box.left   = $signed({1'b0, r_cx}) - $signed({2'b00, r_w[SIZE_W-1:1]});
    assign o_box.top    = $signed({1'b0, r_cy}) - $signed({2'b00, r_h[SIZE_W-1:1]});
    assign o_box.width  = r_w;
    assign o_box.height = r_h;
    assign o_box.index  = n_index;
    assign o_box.best   = n_best;
    assign o_box.conf   = r_conf;

endmodule

// ===== hw/rtl/detection_row_decode_core.sv =====
`timescale 1ns / 1ps
// Top level of the detection row decoder: APB registers, row tracker, score stage.
// Depends on drd_pkg, drd_if and drd_row_track.

// The block takes one sample word per clock cycle, while it is not held off by
// output stalls, with no gaps between rows. A result word reaches the output
// after the last word of its row is accepted through the box register behind
// the row tracker and then the score multiplier that feeds the output register.
// Output stalls back up through these two registers before the input is held off.
module detection_row_decode_core import drd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    drd_in_if.sink                i_sample,
    drd_out_if.source             o_result
);

    localparam int PROD_W = 2 * PROB_W;

    t_cfg               r_cfg;
    logic               w_cfg_write;
    logic               w_emit;
    t_box               w_box;
    t_box               r_s1;
    logic               r_s1_valid;
    logic               r_out_valid;
    logic               w_out_free;
    logic               w_s1_move;
    logic               w_accept;
    logic [PROD_W-1:0]  w_product;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= THRESHOLD_RESET;
            r_cfg.class_count <= CLASS_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_THRESHOLD:   r_cfg.threshold <= pwdata[PROB_W-1:0];
                REG_CLASS_COUNT: r_cfg.class_count <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD:   prdata = APB_DATA_W'(r_cfg.threshold);
            REG_CLASS_COUNT: prdata = APB_DATA_W'(r_cfg.class_count);
            default:         prdata = '0;
        endcase
    end

    assign w_out_free     = !r_out_valid || o_result.ready;
    assign w_s1_move      = r_s1_valid && w_out_free;
    assign i_sample.ready = !r_s1_valid || w_out_free;
    assign w_accept       = i_sample.valid && i_sample.ready;

    drd_row_track #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_sample_value(i_sample.sample_value),
        .i_cfg         (r_cfg),
        .o_emit        (w_emit),
        .o_box         (w_box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1 <= w_box;
        end
    end

    assign w_product = r_s1.best * r_s1.conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            o_result.box_left        <= r_s1.left;
            o_result.box_top         <= r_s1.top;
            o_result.box_width       <= r_s1.width;
            o_result.box_height      <= r_s1.height;
            o_result.class_index     <= r_s1.index;
            o_result.detection_score <= w_product[PROB_W+15:16];
        end
    end

    assign o_result.valid = r_out_valid;

`ifndef ASSERT_OFF
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_free |=> r_s1_valid)
        else $error("Box register dropped a word while the output was stalled.");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> o_result.valid)
        else $error("Box register moved on but no result word followed.");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.detection_score <= PROB_ONE)
        else $error("Detection score exceeds one.");

    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> r_s1_valid && r_out_valid)
        else $error("Input held off while a register stage was free.");
`endif

endmodule

// ===== sim/detection_row_decode_checker.sv =====
`timescale 1ns / 1ps
// Checker for the detection row decoder: tracks register writes, checks register reads,
// predicts each detection from the accepted sample words and compares every result word
// against the prediction. Depends on drd_pkg and the channel interfaces in drd_if.
module detection_row_decode_checker import drd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    drd_in_if                     i_sample,
    drd_out_if                    i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_detections
);

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [INDEX_W-1:0]        index;
        logic [PROB_W-1:0]         score;
    } detection_t;

    logic [PROB_W-1:0]   threshold;
    logic [COUNT_W-1:0]  class_count;
    logic [POS_W-1:0]    row_pos;
    logic [SAMPLE_W-1:0] center_x;
    logic [SAMPLE_W-1:0] center_y;
    logic [SAMPLE_W-1:0] span_w;
    logic [SAMPLE_W-1:0] span_h;
    logic [PROB_W-1:0]   row_conf;
    logic [PROB_W-1:0]   best_score;
    logic [INDEX_W-1:0]  best_index;

    detection_t pending_detections[$];
    int fail_count = 0;
    int waiting = 0;
    int detections = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = waiting;
    assign o_detections = detections;

    function automatic logic [PROB_W-1:0] clamp_prob(input logic [SAMPLE_W-1:0] v);
        return (v > SAMPLE_W'(PROB_ONE)) ? PROB_ONE : v[PROB_W-1:0];
    endfunction

    // Advances the row state by one sample word; returns 1 when the word closes an
    // accepted row, with the detection in det.
    function automatic logic decode_sample(input logic [SAMPLE_W-1:0] v,
                                           output detection_t det);
        int                    classes;
        int                    last;
        logic [PROB_W-1:0]     score;
        logic [SIZE_W-1:0]     wi;
        logic [SIZE_W-1:0]     hi;
        logic [COORD_W:0]      diff_x;
        logic [COORD_W:0]      diff_y;
        logic [2*PROB_W-1:0]   product;
        classes = int'(class_count);
        if (classes == 0) classes = 1;
        if (classes > MAX_CLASSES) classes = MAX_CLASSES;
        last = int'(POS_CONF) + classes;
        det = '0;
        decode_sample = 1'b0;
        case (row_pos)
            POS_CENTER_X: begin
                center_x = v;
                row_pos  = POS_CENTER_Y;
            end
            POS_CENTER_Y: begin
                center_y = v;
                row_pos  = POS_SIZE_W;
            end
            POS_SIZE_W: begin
                span_w  = v;
                row_pos = POS_SIZE_H;
            end
            POS_SIZE_H: begin
                span_h  = v;
                row_pos = POS_CONF;
            end
            POS_CONF: begin
                row_conf = clamp_prob(v);
                row_pos  = POS_FIRST;
            end
            default: begin
                score = clamp_prob(v);
                if (row_pos == POS_FIRST || score > best_score) begin
                    best_score = score;
                    best_index = INDEX_W'(row_pos - POS_FIRST);
                end
                if (int'(row_pos) < last) begin
                    row_pos = row_pos + 1'b1;
                end else begin
                    row_pos = POS_CENTER_X;
                    if (row_conf > threshold) begin
                        wi = span_w[SAMPLE_W-1:FRAC_BITS];
                        hi = span_h[SAMPLE_W-1:FRAC_BITS];
                        diff_x = {2'b00, center_x[SAMPLE_W-1:FRAC_BITS]} - {3'b000, wi[SIZE_W-1:1]};
                        diff_y = {2'b00, center_y[SAMPLE_W-1:FRAC_BITS]} - {3'b000, hi[SIZE_W-1:1]};
                        product = best_score * row_conf;
                        det.left   = diff_x[COORD_W-1:0];
                        det.top    = diff_y[COORD_W-1:0];
                        det.width  = wi;
                        det.height = hi;
                        det.index  = best_index;
                        det.score  = product[16+PROB_W-1:16];
                        decode_sample = 1'b1;
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        detection_t predicted;
        detection_t observed;
        logic [APB_DATA_W-1:0] read_value;
        if (!i_rst_n) begin
            threshold   = THRESHOLD_RESET;
            class_count = CLASS_RESET;
            row_pos     = POS_CENTER_X;
            center_x    = '0;
            center_y    = '0;
            span_w      = '0;
            span_h      = '0;
            row_conf    = '0;
            best_score  = '0;
            best_index  = '0;
            pending_detections.delete();
            waiting = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD) threshold = pwdata[PROB_W-1:0];
                    else class_count = pwdata[COUNT_W-1:0];
                end else begin
                    read_value = (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD) ?
                                 APB_DATA_W'(threshold) : APB_DATA_W'(class_count);
                    if (prdata !== read_value) begin
                        $display("%0t: register read at %0d expected %0d, actual %0d",
                                 $time, paddr, read_value, prdata);
                        fail_count++;
                    end
                end
            end
            if (i_result.valid && i_result.ready) begin
                observed = '{i_result.box_left, i_result.box_top, i_result.box_width,
                             i_result.box_height, i_result.class_index,
                             i_result.detection_score};
                if (pending_detections.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %p",
                             $time, observed);
                    fail_count++;
                end else begin
                    predicted = pending_detections.pop_front();
                    check_field("box_left", int'(predicted.left), int'(observed.left));
                    check_field("box_top", int'(predicted.top), int'(observed.top));
                    check_field("box_width", int'(predicted.width), int'(observed.width));
                    check_field("box_height", int'(predicted.height), int'(observed.height));
                    check_field("class_index", int'(predicted.index), int'(observed.index));
                    check_field("detection_score", int'(predicted.score),
                                int'(observed.score));
                    detections++;
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                if (decode_sample(i_sample.sample_value, predicted))
                    pending_detections.insert(pending_detections.size(), predicted);
            end
            waiting = pending_detections.size();
        end
    end

endmodule

// ===== sim/detection_row_decode_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for detection_row_decode_core: drives registers and sample words
// with random gaps and output stalls; checking is done by detection_row_decode_checker.
// Depends on drd_pkg, drd_if, the core and the checker.
module detection_row_decode_core_tb;
    import drd_pkg::*;

    localparam int MAX_CLASSES   = 128;
    localparam int PHASES        = 7;
    localparam int IDLE_PERCENT  = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 10000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int detections;
    int words_sent = 0;
    int rows_sent = 0;
    int cfg_threshold = int'(THRESHOLD_RESET);
    int cfg_classes = int'(CLASS_RESET);
    bit calm = 1'b0;

    int phase_threshold[PHASES] = '{16384, 0, 65536, 32768, 1000, 65535, 40000};
    int phase_classes[PHASES]   = '{4, 0, 1, 255, 3, 128, 2};
    int phase_words[PHASES]     = '{180, 180, 144, 133, 176, 133, 182};

    drd_in_if  sample_ch ();
    drd_out_if result_ch ();

    always #1 i_clk = ~i_clk;

    detection_row_decode_core #(.MAX_CLASSES(MAX_CLASSES)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_sample (sample_ch),
        .o_result (result_ch)
    );

    detection_row_decode_checker #(.MAX_CLASSES(MAX_CLASSES)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_sample     (sample_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_detections (detections)
    );

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input int value);
        apb_access(1'b1, {index, 2'b00}, APB_DATA_W'(value));
        apb_access(1'b0, {index, 2'b00}, '0);
        if (index == REG_THRESHOLD) cfg_threshold = value;
        else cfg_classes = value;
    endtask

    function automatic int row_classes();
        int classes = cfg_classes & 8'hFF;
        if (classes == 0) classes = 1;
        if (classes > MAX_CLASSES) classes = MAX_CLASSES;
        return classes;
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] value);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                sample_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= value;
        do @(posedge i_clk); while (!sample_ch.ready);
        words_sent++;
    endtask

    task automatic settle();
        int waited = 0;
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_confidence();
        int thr = cfg_threshold;
        case ($urandom_range(4))
            0: return (thr < 65536) ? SAMPLE_W'($urandom_range(65536, thr + 1)) : SAMPLE_W'(65536);
            1: return SAMPLE_W'($urandom_range(20'hFFFFF, 65537));
            2: return SAMPLE_W'($urandom_range(thr, 0));
            3: return SAMPLE_W'($urandom);
            default: return SAMPLE_W'(thr);
        endcase
    endfunction

    task automatic send_row();
        int classes = row_classes();
        logic [SAMPLE_W-1:0] score = '0;
        repeat (4) send_word(SAMPLE_W'($urandom));
        send_word(pick_confidence());
        for (int i = 0; i < classes; i++) begin
            case ($urandom_range(4)) inside
                0: score = SAMPLE_W'($urandom);
                [1:2]: score = SAMPLE_W'($urandom_range(65536));
                3: ;
                default: score = $urandom_range(1) ? SAMPLE_W'(65536) : '0;
            endcase
            send_word(score);
        end
        rows_sent++;
    endtask

    initial begin
        int start;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_access(1'b0, {REG_THRESHOLD, 2'b00}, '0);
        apb_access(1'b0, {REG_CLASS_COUNT, 2'b00}, '0);
        write_register(REG_CLASS_COUNT, 2);
        write_register(REG_THRESHOLD, 0);

        // Extreme box edges, saturated confidence and a tie between saturated scores.
        send_word(20'hFFFFF);
        send_word(20'h00000);
        send_word(20'h00000);
        send_word(20'hFFFFF);
        send_word(20'hFFFFF);
        send_word(20'h10000);
        send_word(20'hFFFFF);
        // Confidence equal to the threshold is rejected.
        send_word(20'h00000);
        send_word(20'hFFFFF);
        send_word(20'hFFFFF);
        send_word(20'h00000);
        send_word(20'h00000);
        send_word(20'h00000);
        send_word(20'h00001);
        // Class count lowered in the middle of a row.
        settle();
        write_register(REG_CLASS_COUNT, 3);
        send_word(20'h12345);
        send_word(20'h54321);
        send_word(20'h00F0F);
        send_word(20'h0F0F0);
        send_word(20'h00001);
        send_word(20'h00007);
        settle();
        write_register(REG_CLASS_COUNT, 1);
        send_word(20'h00009);
        rows_sent += 3;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_register(REG_THRESHOLD, phase_threshold[p]);
            write_register(REG_CLASS_COUNT, phase_classes[p]);
            calm = (p == 4);
            start = words_sent;
            while (words_sent - start < phase_words[p]) send_row();
        end
        calm = 1'b0;
        settle();

        $display("summary: %0d sample words in %0d rows over %0d register settings",
                 words_sent, rows_sent, PHASES + 3);
        $display("summary: %0d detections compared, %0d still outstanding", detections, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/drd_pkg.sv
hw/rtl/drd_if.sv
hw/rtl/drd_row_track.sv
hw/rtl/detection_row_decode_core.sv
sim/detection_row_decode_checker.sv
sim/detection_row_decode_core_tb.sv
